// ----- rtl/wav_riff_chunk_parser_core_macros.svh -----
// ---------------------------------------------------------------------------
// WAV RIFF chunk parser assertion macros
// Clocked, reset-qualified property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef WAV_RIFF_CHUNK_PARSER_CORE_MACROS_SVH
`define WAV_RIFF_CHUNK_PARSER_CORE_MACROS_SVH

// Same-cycle implication
`define WAVRP_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define WAVRP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/wavrp_pkg.sv -----
// ---------------------------------------------------------------------------
// WAV RIFF chunk parser package
// Result codes, chunk tags, parser phases and the result record.
// ---------------------------------------------------------------------------
package wavrp_pkg;

  localparam logic [1:0] KIND_AUDIO  = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_RIFF_TAG  = 2'd1;
  localparam logic [1:0] ERR_WAVE_TAG  = 2'd2;
  localparam logic [1:0] ERR_EARLY_END = 2'd3;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // bytes of fmt that carry reported fields
  localparam int FMT_FIELD_BYTES = 18;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef enum logic [9:0] {
    PH_RIFF  = 10'b00_0000_0001,
    PH_RSIZE = 10'b00_0000_0010,
    PH_WAVE  = 10'b00_0000_0100,
    PH_ID    = 10'b00_0000_1000,
    PH_SIZE  = 10'b00_0001_0000,
    PH_FMT   = 10'b00_0010_0000,
    PH_DATA  = 10'b00_0100_0000,
    PH_SKIP  = 10'b00_1000_0000,
    PH_PAD   = 10'b01_0000_0000,
    PH_HALT  = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  audio_byte;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [15:0] extra_size;
    logic [1:0]  error_code;
    logic        last_result;
  } res_t;

endpackage

// ----- rtl/wav_riff_chunk_parser_core.sv -----
// ---------------------------------------------------------------------------
// WAV RIFF chunk parser core
// Walks a RIFF/WAVE byte stream, passes out data chunk bytes, reports the
// fmt fields and ends with a done or error result.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one file byte per transfer, with
//   in_stream_end set on the last byte of the file. Output channel
//   (out_valid/out_stall) gives one result per transfer: audio byte, format
//   report, done or error. Done and error carry out_last_result.
//   Each result is written to the result queue when its byte is taken.
//   Throughput: one byte per cycle while in_stall is low; the parse state
//   is registered per taken byte; results go into a four-entry result queue.
//   A byte can cause up to two results, so in_stall rises while three or more
//   results are queued. When the receiver stalls, the queue fills and then
//   holds the input; the head result stays stable on the output ports.
//   After done or error every byte is taken and dropped until reset.
//   Reset (rst_n low, synchronous) empties the queue and rearms the parser
//   for a RIFF tag; no clearing pass is needed.
// ---------------------------------------------------------------------------
module wav_riff_chunk_parser_core #(
  parameter int FORMAT_BYTES = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_audio_byte,
  output logic [15:0] out_format_tag,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [31:0] out_byte_rate,
  output logic [15:0] out_block_align,
  output logic [15:0] out_bits_per_sample,
  output logic [15:0] out_extra_size,
  output logic [1:0]  out_error_code,
  output logic        out_last_result
);
  import wavrp_pkg::*;

  localparam int StoreBytes = (FORMAT_BYTES < FMT_FIELD_BYTES) ? FORMAT_BYTES
                                                               : FMT_FIELD_BYTES;
  localparam int IdxW = $clog2(StoreBytes);
  localparam int CntW = $clog2(StoreBytes + 1);

  phase_t            phase_r, phase_nxt;
  logic [1:0]        field_idx_r, field_idx_nxt;
  logic [31:0]       tag_r, tag_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [31:0]       left_r, left_nxt;
  logic [CntW-1:0]   fmt_cnt_r, fmt_cnt_nxt;
  logic              fmt_seen_r, fmt_seen_nxt;
  logic              data_seen_r, data_seen_nxt;
  logic [7:0]        fmt_q_r [StoreBytes];
  logic [7:0]        fmt_view [FMT_FIELD_BYTES];

  logic              fmt_clr, fmt_wr;
  logic              body_end;
  logic              pri_vld, pri_fmt;
  logic              fin_vld, fin_err;
  logic [1:0]        fin_code;
  res_t              res_pri, res_fin, slot0;
  logic [1:0]        n_push;

  res_t              q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] q_cnt_r, q_cnt_nxt;

  logic              in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // parse step
  always_comb begin
    phase_nxt     = phase_r;
    field_idx_nxt = field_idx_r;
    tag_nxt       = tag_r;
    len_nxt       = len_r;
    left_nxt      = left_r;
    fmt_cnt_nxt   = fmt_cnt_r;
    fmt_seen_nxt  = fmt_seen_r;
    data_seen_nxt = data_seen_r;
    fmt_clr       = 1'b0;
    fmt_wr        = 1'b0;
    body_end      = 1'b0;
    pri_vld       = 1'b0;
    pri_fmt       = 1'b0;
    fin_vld       = 1'b0;
    fin_err       = 1'b0;
    fin_code      = ERR_NONE;

    case (phase_r)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE: begin
        if (phase_r == PH_SIZE) begin
          len_nxt = {in_data_byte, len_r[31:8]};
        end else begin
          tag_nxt = {tag_r[23:0], in_data_byte};
        end
        field_idx_nxt = field_idx_r + 2'd1;
        if (field_idx_r == 2'd3) begin
          case (phase_r)
            PH_RIFF: begin
              if (tag_nxt != TAG_RIFF) begin
                fin_vld   = 1'b1;
                fin_err   = 1'b1;
                fin_code  = ERR_RIFF_TAG;
                phase_nxt = PH_HALT;
              end else begin
                phase_nxt = PH_RSIZE;
              end
            end
            PH_RSIZE: phase_nxt = PH_WAVE;
            PH_WAVE: begin
              if (tag_nxt != TAG_WAVE) begin
                fin_vld   = 1'b1;
                fin_err   = 1'b1;
                fin_code  = ERR_WAVE_TAG;
                phase_nxt = PH_HALT;
              end else begin
                phase_nxt = PH_ID;
              end
            end
            PH_ID: phase_nxt = PH_SIZE;
            default: begin
              left_nxt = len_nxt;
              if (tag_r == TAG_FMT) begin
                fmt_clr     = 1'b1;
                fmt_cnt_nxt = '0;
                if (len_nxt == 32'd0) begin
                  pri_vld      = 1'b1;
                  pri_fmt      = 1'b1;
                  fmt_seen_nxt = 1'b1;
                  body_end     = 1'b1;
                end else begin
                  phase_nxt = PH_FMT;
                end
              end else if (tag_r == TAG_DATA) begin
                if (len_nxt == 32'd0) begin
                  data_seen_nxt = 1'b1;
                  body_end      = 1'b1;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end else if (len_nxt == 32'd0) begin
                body_end = 1'b1;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          endcase
        end
      end
      PH_FMT: begin
        if (fmt_cnt_r < CntW'(StoreBytes)) begin
          fmt_wr      = 1'b1;
          fmt_cnt_nxt = fmt_cnt_r + CntW'(1);
        end
        left_nxt = left_r - 32'd1;
        if (left_r == 32'd1) begin
          pri_vld      = 1'b1;
          pri_fmt      = 1'b1;
          fmt_seen_nxt = 1'b1;
          body_end     = 1'b1;
        end
      end
      PH_DATA: begin
        pri_vld  = 1'b1;
        left_nxt = left_r - 32'd1;
        if (left_r == 32'd1) begin
          data_seen_nxt = 1'b1;
          body_end      = 1'b1;
        end
      end
      PH_SKIP: begin
        left_nxt = left_r - 32'd1;
        if (left_r == 32'd1) begin
          body_end = 1'b1;
        end
      end
      PH_PAD: begin
        field_idx_nxt = 2'd0;
        phase_nxt     = PH_ID;
      end
      default: phase_nxt = PH_HALT;
    endcase

    if (body_end) begin
      field_idx_nxt = 2'd0;
      if (fmt_seen_nxt && data_seen_nxt) begin
        fin_vld   = 1'b1;
        phase_nxt = PH_HALT;
      end else if (len_nxt[0]) begin
        phase_nxt = PH_PAD;
      end else begin
        phase_nxt = PH_ID;
      end
    end

    // end of file
    if (in_stream_end && phase_r != PH_HALT && phase_nxt != PH_HALT) begin
      if (phase_nxt == PH_FMT) begin
        pri_vld      = 1'b1;
        pri_fmt      = 1'b1;
        fmt_seen_nxt = 1'b1;
      end else if (phase_nxt == PH_DATA) begin
        data_seen_nxt = 1'b1;
      end
      fin_vld = 1'b1;
      if (!(fmt_seen_nxt && data_seen_nxt)) begin
        fin_err  = 1'b1;
        fin_code = ERR_EARLY_END;
      end
      phase_nxt = PH_HALT;
    end
  end

  // fmt store as it stands after this byte
  always_comb begin
    for (int j = 0; j < FMT_FIELD_BYTES; j++) begin
      fmt_view[j] = 8'd0;
    end
    for (int j = 0; j < StoreBytes; j++) begin
      if (fmt_clr) begin
        fmt_view[j] = 8'd0;
      end else if (fmt_wr && fmt_cnt_r[IdxW-1:0] == IdxW'(j)) begin
        fmt_view[j] = in_data_byte;
      end else begin
        fmt_view[j] = fmt_q_r[j];
      end
    end
  end

  always_comb begin
    res_pri = '0;
    if (pri_fmt) begin
      res_pri.result_kind     = KIND_FORMAT;
      res_pri.format_tag      = {fmt_view[1], fmt_view[0]};
      res_pri.channel_count   = {fmt_view[3], fmt_view[2]};
      res_pri.sample_rate     = {fmt_view[7], fmt_view[6], fmt_view[5], fmt_view[4]};
      res_pri.byte_rate       = {fmt_view[11], fmt_view[10], fmt_view[9], fmt_view[8]};
      res_pri.block_align     = {fmt_view[13], fmt_view[12]};
      res_pri.bits_per_sample = {fmt_view[15], fmt_view[14]};
      res_pri.extra_size      = {fmt_view[17], fmt_view[16]};
    end else begin
      res_pri.result_kind = KIND_AUDIO;
      res_pri.audio_byte  = in_data_byte;
    end

    res_fin             = '0;
    res_fin.result_kind = fin_err ? KIND_ERROR : KIND_DONE;
    res_fin.error_code  = fin_code;
    res_fin.last_result = 1'b1;

    slot0  = pri_vld ? res_pri : res_fin;
    n_push = in_acc ? ({1'b0, pri_vld} + {1'b0, fin_vld}) : 2'd0;
  end

  assign q_cnt_nxt = q_cnt_r + Q_CNT_W'(n_push) - Q_CNT_W'(out_acc);

  assign in_stall  = (q_cnt_r > Q_CNT_W'(Q_DEPTH - 2));
  assign out_valid = (q_cnt_r != '0);

  assign out_result_kind     = q_r[rd_ptr_r].result_kind;
  assign out_audio_byte      = q_r[rd_ptr_r].audio_byte;
  assign out_format_tag      = q_r[rd_ptr_r].format_tag;
  assign out_channel_count   = q_r[rd_ptr_r].channel_count;
  assign out_sample_rate     = q_r[rd_ptr_r].sample_rate;
  assign out_byte_rate       = q_r[rd_ptr_r].byte_rate;
  assign out_block_align     = q_r[rd_ptr_r].block_align;
  assign out_bits_per_sample = q_r[rd_ptr_r].bits_per_sample;
  assign out_extra_size      = q_r[rd_ptr_r].extra_size;
  assign out_error_code      = q_r[rd_ptr_r].error_code;
  assign out_last_result     = q_r[rd_ptr_r].last_result;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      field_idx_r <= 2'd0;
      fmt_seen_r  <= 1'b0;
      data_seen_r <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      q_cnt_r     <= '0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        field_idx_r <= field_idx_nxt;
        fmt_seen_r  <= fmt_seen_nxt;
        data_seen_r <= data_seen_nxt;
      end
      wr_ptr_r <= wr_ptr_r + Q_PTR_W'(n_push);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_r     <= tag_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      fmt_cnt_r <= fmt_cnt_nxt;
      for (int j = 0; j < StoreBytes; j++) begin
        fmt_q_r[j] <= fmt_view[j];
      end
    end
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= slot0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_r + Q_PTR_W'(1)] <= res_fin;
    end
  end

endmodule

// ----- rtl/wavrp_checker.sv -----
// ---------------------------------------------------------------------------
// WAV RIFF chunk parser port checker
// Watches the result channel of the parser core over time.
// ---------------------------------------------------------------------------
`include "wav_riff_chunk_parser_core_macros.svh"

module wavrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_result_kind,
  input logic [7:0]  out_audio_byte,
  input logic [15:0] out_format_tag,
  input logic [31:0] out_sample_rate,
  input logic [1:0]  out_error_code,
  input logic        out_last_result
);
  import wavrp_pkg::*;

  `WAVRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result_kind) && $stable(out_audio_byte) && $stable(out_last_result), "result changed while stalled")

  `WAVRP_ASSERT_NEXT(a_last_is_final, out_valid && !out_stall && out_last_result, !out_valid, "result follows the final transfer")

  `WAVRP_ASSERT_NOW(a_err_code_kind, out_valid && out_result_kind != KIND_ERROR, out_error_code == ERR_NONE, "error code outside an error result")

  `WAVRP_ASSERT_NOW(a_audio_clean, out_valid && out_result_kind == KIND_AUDIO, !out_last_result && out_format_tag == 16'd0 && out_sample_rate == 32'd0, "audio result carries other fields")

endmodule

bind wav_riff_chunk_parser_core wavrp_checker u_wavrp_checker (.*);

// ----- test/wav_riff_chunk_parser_checker.sv -----
// ---------------------------------------------------------------------------
// WAV RIFF chunk parser checker
// Watches both channels of the parser core. Each byte transfer runs through a
// cycle-free model of the RIFF/WAVE walk, and each result transfer is compared
// field by field with the oldest predicted result.
// ---------------------------------------------------------------------------
module wav_riff_chunk_parser_checker #(
  parameter int FORMAT_BYTES = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_result_kind,
  input  logic [7:0]  out_audio_byte,
  input  logic [15:0] out_format_tag,
  input  logic [15:0] out_channel_count,
  input  logic [31:0] out_sample_rate,
  input  logic [31:0] out_byte_rate,
  input  logic [15:0] out_block_align,
  input  logic [15:0] out_bits_per_sample,
  input  logic [15:0] out_extra_size,
  input  logic [1:0]  out_error_code,
  input  logic        out_last_result,
  output int          fail_count,
  output int          outstanding,
  output int          checked
);
  import wavrp_pkg::*;

  phase_t      phase;
  logic [1:0]  fidx;
  logic [31:0] tag_acc;
  logic [31:0] chunk_len;
  logic [31:0] remaining;
  logic [7:0]  fmt_buf [FORMAT_BYTES];
  logic        fmt_seen;
  logic        data_seen;
  res_t        parsed_results [$];
  res_t        got;
  res_t        want;

  function automatic logic [15:0] fmt_half(input int i);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = (i < FORMAT_BYTES) ? fmt_buf[i] : 8'h00;
    hi = (i + 1 < FORMAT_BYTES) ? fmt_buf[i + 1] : 8'h00;
    return {hi, lo};
  endfunction

  task automatic post_format();
    res_t r;
    r = '0;
    r.result_kind     = KIND_FORMAT;
    r.format_tag      = fmt_half(0);
    r.channel_count   = fmt_half(2);
    r.sample_rate     = {fmt_half(6), fmt_half(4)};
    r.byte_rate       = {fmt_half(10), fmt_half(8)};
    r.block_align     = fmt_half(12);
    r.bits_per_sample = fmt_half(14);
    r.extra_size      = fmt_half(16);
    parsed_results.push_back(r);
    fmt_seen = 1'b1;
  endtask

  task automatic post_last(input logic [1:0] kind, input logic [1:0] code);
    res_t r;
    r = '0;
    r.result_kind = kind;
    r.error_code  = code;
    r.last_result = 1'b1;
    parsed_results.push_back(r);
    phase = PH_HALT;
  endtask

  // done is not held back for the pad byte
  task automatic close_chunk();
    fidx = 2'd0;
    if (fmt_seen && data_seen) begin
      post_last(KIND_DONE, ERR_NONE);
    end else if (chunk_len[0]) begin
      phase = PH_PAD;
    end else begin
      phase = PH_ID;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eos);
    res_t        r;
    logic [31:0] idx;
    if (phase != PH_HALT) begin
      case (phase)
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE: begin
          if (phase == PH_SIZE) begin
            chunk_len = {b, chunk_len[31:8]};
          end else begin
            tag_acc = {tag_acc[23:0], b};
          end
          fidx = fidx + 2'd1;
          if (fidx == 2'd0) begin
            case (phase)
              PH_RIFF: begin
                if (tag_acc != TAG_RIFF) post_last(KIND_ERROR, ERR_RIFF_TAG);
                else phase = PH_RSIZE;
              end
              PH_RSIZE: phase = PH_WAVE;
              PH_WAVE: begin
                if (tag_acc != TAG_WAVE) post_last(KIND_ERROR, ERR_WAVE_TAG);
                else phase = PH_ID;
              end
              PH_ID: phase = PH_SIZE;
              default: begin
                remaining = chunk_len;
                if (tag_acc == TAG_FMT) begin
                  foreach (fmt_buf[k]) fmt_buf[k] = 8'h00;
                  if (remaining == 32'd0) begin
                    post_format();
                    close_chunk();
                  end else begin
                    phase = PH_FMT;
                  end
                end else if (tag_acc == TAG_DATA) begin
                  if (remaining == 32'd0) begin
                    data_seen = 1'b1;
                    close_chunk();
                  end else begin
                    phase = PH_DATA;
                  end
                end else if (remaining == 32'd0) begin
                  close_chunk();
                end else begin
                  phase = PH_SKIP;
                end
              end
            endcase
          end
        end
        PH_FMT: begin
          idx = chunk_len - remaining;
          if (idx < FORMAT_BYTES) fmt_buf[idx] = b;
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) begin
            post_format();
            close_chunk();
          end
        end
        PH_DATA: begin
          r = '0;
          r.result_kind = KIND_AUDIO;
          r.audio_byte  = b;
          parsed_results.push_back(r);
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) begin
            data_seen = 1'b1;
            close_chunk();
          end
        end
        PH_SKIP: begin
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) close_chunk();
        end
        PH_PAD: begin
          fidx  = 2'd0;
          phase = PH_ID;
        end
        default: phase = PH_HALT;
      endcase
      // end of file: a cut fmt or data body still counts as seen
      if (eos && phase != PH_HALT) begin
        if (phase == PH_FMT) begin
          post_format();
        end else if (phase == PH_DATA) begin
          data_seen = 1'b1;
        end
        if (fmt_seen && data_seen) post_last(KIND_DONE, ERR_NONE);
        else post_last(KIND_ERROR, ERR_EARLY_END);
      end
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] seen,
                               input logic [31:0] due);
    fail_count++;
    if (fail_count <= 40) begin
      $display("mismatch on result %0d: %s is %0h, expected %0h", checked, what, seen, due);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase     = PH_RIFF;
      fidx      = 2'd0;
      tag_acc   = 32'd0;
      chunk_len = 32'd0;
      remaining = 32'd0;
      foreach (fmt_buf[k]) fmt_buf[k] = 8'h00;
      fmt_seen  = 1'b0;
      data_seen = 1'b0;
      parsed_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_result_kind, out_audio_byte, out_format_tag, out_channel_count,
               out_sample_rate, out_byte_rate, out_block_align, out_bits_per_sample,
               out_extra_size, out_error_code, out_last_result};
        if (parsed_results.size() == 0) begin
          note_mismatch("result with none pending, kind", got.result_kind, '0);
        end else begin
          want = parsed_results.pop_front();
          if (got.result_kind !== want.result_kind)
            note_mismatch("result_kind", got.result_kind, want.result_kind);
          if (got.audio_byte !== want.audio_byte)
            note_mismatch("audio_byte", got.audio_byte, want.audio_byte);
          if (got.format_tag !== want.format_tag)
            note_mismatch("format_tag", got.format_tag, want.format_tag);
          if (got.channel_count !== want.channel_count)
            note_mismatch("channel_count", got.channel_count, want.channel_count);
          if (got.sample_rate !== want.sample_rate)
            note_mismatch("sample_rate", got.sample_rate, want.sample_rate);
          if (got.byte_rate !== want.byte_rate)
            note_mismatch("byte_rate", got.byte_rate, want.byte_rate);
          if (got.block_align !== want.block_align)
            note_mismatch("block_align", got.block_align, want.block_align);
          if (got.bits_per_sample !== want.bits_per_sample)
            note_mismatch("bits_per_sample", got.bits_per_sample, want.bits_per_sample);
          if (got.extra_size !== want.extra_size)
            note_mismatch("extra_size", got.extra_size, want.extra_size);
          if (got.error_code !== want.error_code)
            note_mismatch("error_code", got.error_code, want.error_code);
          if (got.last_result !== want.last_result)
            note_mismatch("last_result", got.last_result, want.last_result);
        end
        checked++;
      end
      if (in_valid && !in_stall) parse_byte(in_data_byte, in_stream_end);
    end
    outstanding = parsed_results.size();
  end

endmodule

// ----- test/wav_riff_chunk_parser_core_tb.sv -----
// ---------------------------------------------------------------------------
// WAV RIFF chunk parser core testbench
// Builds one long WAV byte stream (a directed header, in some runs with a
// corrupted tag, else zero-size chunks, then random fmt, data and foreign
// chunks with a randomly chosen ending), feeds it through the core with
// random gaps and output stalls, and lets the checker predict and compare every result.
// ---------------------------------------------------------------------------
module wav_riff_chunk_parser_core_tb;
  import wavrp_pkg::*;

  localparam int FMT_BYTES   = 18;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum {LAYOUT_BAD_HEADER, LAYOUT_FMT_FIRST, LAYOUT_DATA_FIRST} layout_t;
  typedef enum {ENDING_FULL, ENDING_CUT_BODY, ENDING_EARLY, ENDING_CUT_HEAD} ending_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_stream_end;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_audio_byte;
  logic [15:0] out_format_tag;
  logic [15:0] out_channel_count;
  logic [31:0] out_sample_rate;
  logic [31:0] out_byte_rate;
  logic [15:0] out_block_align;
  logic [15:0] out_bits_per_sample;
  logic [15:0] out_extra_size;
  logic [1:0]  out_error_code;
  logic        out_last_result;
  int          fail_count;
  int          outstanding;
  int          checked;
  int          cycle_count;
  logic        calm;
  logic [8:0]  wav_stream [$];
  layout_t     layout;
  ending_t     ending;

  wav_riff_chunk_parser_core #(.FORMAT_BYTES(FMT_BYTES)) uut (.*);

  wav_riff_chunk_parser_checker #(.FORMAT_BYTES(FMT_BYTES)) u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    wav_stream.push_back({1'b0, b});
  endtask

  // chunk ids go out first character first
  task automatic add_tag(input logic [31:0] t);
    for (int k = 3; k >= 0; k--) add_byte(t[8*k +: 8]);
  endtask

  task automatic add_word_le(input logic [31:0] v);
    for (int k = 0; k < 4; k++) add_byte(v[8*k +: 8]);
  endtask

  task automatic add_body(input int unsigned n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_chunk(input logic [31:0] id, input int unsigned len);
    add_tag(id);
    add_word_le(len);
    add_body(len);
    if (len % 2) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic mark_end(input int idx);
    wav_stream[idx] = {1'b1, wav_stream[idx][7:0]};
  endtask

  // foreign ids, often one bit away from fmt or data
  function automatic logic [31:0] other_id();
    logic [31:0] id;
    do begin
      case ($urandom_range(0, 2))
        0: id = $urandom();
        1: id = TAG_FMT ^ (32'd1 << $urandom_range(0, 31));
        default: id = TAG_DATA ^ (32'd1 << $urandom_range(0, 31));
      endcase
    end while (id == TAG_FMT || id == TAG_DATA);
    return id;
  endfunction

  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end
    end
  end

  initial begin
    int          pick;
    int          cut;
    int          target;
    int unsigned len;
    logic [31:0] last_id;
    string       shape;
    string       tail_desc;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = 8'h00;
    in_stream_end = 1'b0;
    calm          = 1'b0;

    pick = $urandom_range(0, 9);
    if (pick == 0) layout = LAYOUT_BAD_HEADER;
    else if (pick < 6) layout = LAYOUT_FMT_FIRST;
    else layout = LAYOUT_DATA_FIRST;
    ending = ending_t'($urandom_range(0, 3));

    add_tag(TAG_RIFF);
    add_word_le(32'hFF00_00FF);
    add_tag(TAG_WAVE);
    if (layout == LAYOUT_BAD_HEADER) begin
      cut  = $urandom_range(0, 1) * 8;
      pick = cut + $urandom_range(0, 3);
      wav_stream[pick] = wav_stream[pick] ^ (9'd1 << $urandom_range(0, 7));
      if ($urandom_range(0, 1)) mark_end(cut + 3);
      shape     = "a corrupted header tag";
      tail_desc = "stopped at the header";
    end else begin
      add_chunk(other_id(), 0);
      add_chunk(layout == LAYOUT_FMT_FIRST ? TAG_FMT : TAG_DATA, 0);
      last_id = (layout == LAYOUT_FMT_FIRST) ? TAG_DATA : TAG_FMT;
      if (layout == LAYOUT_FMT_FIRST && (ending == ENDING_FULL || ending == ENDING_CUT_BODY))
        target = 780;
      else
        target = 1020;
      while (wav_stream.size() < target) begin
        if ($urandom_range(0, 9) < 5) begin
          if (layout == LAYOUT_FMT_FIRST) begin
            case ($urandom_range(0, 5))
              0, 1: len = 16;
              2: len = 18;
              3: len = $urandom_range(0, 15);
              4: len = $urandom_range(19, 40);
              default: len = $urandom_range(41, 64);
            endcase
            add_chunk(TAG_FMT, len);
          end else begin
            add_chunk(TAG_DATA, $urandom_range(0, 48));
          end
        end else begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
          add_chunk(other_id(), len);
        end
      end
      case (ending)
        ENDING_FULL: begin
          len = (layout == LAYOUT_FMT_FIRST) ? $urandom_range(200, 320) : $urandom_range(14, 40);
          add_chunk(last_id, len);
          if ($urandom_range(0, 1)) mark_end(wav_stream.size() - 1 - int'(len % 2));
          tail_desc = "a complete closing chunk";
        end
        ENDING_CUT_BODY: begin
          add_tag(last_id);
          add_word_le($urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom() | 32'h0001_0000));
          add_body((layout == LAYOUT_FMT_FIRST) ? $urandom_range(200, 320) : $urandom_range(1, 30));
          mark_end(wav_stream.size() - 1);
          tail_desc = "a closing chunk cut inside its body";
        end
        ENDING_EARLY: begin
          mark_end(wav_stream.size() - 1 - $urandom_range(0, 15));
          tail_desc = "an end before the closing chunk";
        end
        default: begin
          add_tag(last_id);
          add_word_le($urandom_range(0, 40));
          mark_end(wav_stream.size() - 1 - $urandom_range(0, 7));
          tail_desc = "an end inside the closing chunk header";
        end
      endcase
      shape = (layout == LAYOUT_FMT_FIRST) ? "repeated fmt chunks before data"
                                           : "repeated data chunks before fmt";
    end
    // trailing bytes after the verdict must be dropped
    repeat ($urandom_range(16, 40)) wav_stream.push_back(9'($urandom_range(0, 511)));
    while (wav_stream.size() < 1040) wav_stream.push_back(9'($urandom_range(0, 511)));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < wav_stream.size(); i++) begin
      calm <= (i > wav_stream.size() * 9 / 10);
      if (i == wav_stream.size() / 2) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      in_valid <= 1'b1;
      {in_stream_end, in_data_byte} <= wav_stream[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("covered %0d stream bytes with %s and %s", wav_stream.size(), shape, tail_desc);
    $display("%0d results compared", checked);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
